/* hw/rtl/spr_pkg.sv */
// ---------------------------------------------------------------------------
// spr_pkg
// Shared widths, reset values and types of the systematic particle resampler.
// ---------------------------------------------------------------------------
package spr_pkg;

  localparam int DEF_MAX_PARTICLES    = 1024;
  localparam int DEF_WEIGHT_FRAC_BITS = 24;

  localparam int W_POS     = 32;
  localparam int W_HEADING = 16;
  localparam int W_WEIGHT  = 25;
  localparam int W_OFFSET  = 16;
  localparam int W_COUNT   = 11;
  localparam int W_INDEX   = 10;

  localparam logic [W_COUNT-1:0] COUNT_RESET = W_COUNT'(1024);

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [W_POS-1:0]     x;
    logic signed [W_POS-1:0]     y;
    logic signed [W_HEADING-1:0] heading;
  } spr_pose_t;

  // first: item opens a set, last: item closes it
  typedef struct packed {
    logic first;
    logic last;
  } spr_flags_t;

endpackage

/* hw/rtl/spr_if.sv */
// ---------------------------------------------------------------------------
// spr_if
// Valid/ready channels of the resampler: particle in, result out, config.
// ---------------------------------------------------------------------------
interface spr_in_if import spr_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [W_POS-1:0]     pos_x;
  logic signed [W_POS-1:0]     pos_y;
  logic signed [W_HEADING-1:0] heading;
  logic [W_WEIGHT-1:0]         weight;
  logic [W_OFFSET-1:0]         random_offset;
  logic                        last;

  modport source (output valid, pos_x, pos_y, heading, weight, random_offset, last,
                  input ready);
  modport sink (input valid, pos_x, pos_y, heading, weight, random_offset, last,
                output ready);
endinterface

interface spr_out_if import spr_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [W_POS-1:0]     out_x;
  logic signed [W_POS-1:0]     out_y;
  logic signed [W_HEADING-1:0] out_heading;
  logic [W_COUNT-1:0]          copies;
  logic [W_INDEX-1:0]          source_index;
  logic                        set_done;

  modport source (output valid, out_x, out_y, out_heading, copies, source_index, set_done,
                  input ready);
  modport sink (input valid, out_x, out_y, out_heading, copies, source_index, set_done,
                output ready);
endinterface

interface spr_cfg_if import spr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [W_COUNT-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* hw/rtl/spr_front.sv */
// ---------------------------------------------------------------------------
// spr_front
// Takes particle requests, tracks set boundaries and the running weight sum.
// ---------------------------------------------------------------------------
module spr_front import spr_pkg::*; #(
  parameter int MAX_PARTICLES    = DEF_MAX_PARTICLES,
  parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS,
  localparam int SW = WEIGHT_FRAC_BITS + 2,
  localparam int IW = $clog2(MAX_PARTICLES)
) (
  input  logic                clk,
  input  logic                rst_n,
  spr_in_if.sink              in_chan,
  output logic                push_valid,
  input  logic                push_ready,
  output spr_pose_t           push_pose,
  output logic [SW-1:0]       push_sum,
  output logic [W_OFFSET-1:0] push_offset,
  output spr_flags_t          push_flags,
  output logic [IW-1:0]       push_idx
);

  localparam int AW = ((SW > W_WEIGHT) ? SW : W_WEIGHT) + 1;
  localparam logic [SW-1:0] SUM_MAX = '1;
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_PARTICLES - 1);

  logic [SW-1:0]       sum_r, sum_nxt, sum_base;
  logic [W_OFFSET-1:0] offset_r, offset_nxt;
  logic [IW-1:0]       pos_r, pos_nxt, idx;
  logic                start_r, start_nxt;
  logic [AW-1:0]       sum_ext;
  logic                accept;

  assign in_chan.ready = push_ready;
  assign accept        = in_chan.valid & push_ready;

  always_comb begin
    sum_base   = start_r ? '0 : sum_r;
    offset_nxt = start_r ? in_chan.random_offset : offset_r;
    idx        = start_r ? '0 : pos_r;
    sum_ext    = AW'(sum_base) + AW'(in_chan.weight);
    // saturate; anything at or above 1.0 already passes every threshold
    sum_nxt    = (sum_ext > AW'(SUM_MAX)) ? SUM_MAX : SW'(sum_ext);
    pos_nxt    = (idx == IDX_LAST) ? '0 : idx + IW'(1);
    start_nxt  = in_chan.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      offset_r <= '0;
      pos_r    <= '0;
      start_r  <= 1'b1;
    end else if (accept) begin
      sum_r    <= sum_nxt;
      offset_r <= offset_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
    end
  end

  assign push_valid        = in_chan.valid;
  assign push_pose.x       = in_chan.pos_x;
  assign push_pose.y       = in_chan.pos_y;
  assign push_pose.heading = in_chan.heading;
  assign push_sum          = sum_nxt;
  assign push_offset       = offset_nxt;
  assign push_flags.first  = start_r;
  assign push_flags.last   = in_chan.last;
  assign push_idx          = idx;

endmodule

/* hw/rtl/spr_queue.sv */
// ---------------------------------------------------------------------------
// spr_queue
// Short FIFO between the front and back halves.
// ---------------------------------------------------------------------------
module spr_queue import spr_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             push, pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue fill beyond depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("queue fill lost a request");

endmodule

/* hw/rtl/spr_back.sv */
// ---------------------------------------------------------------------------
// spr_back
// Threshold count per particle: multiply, compare and clamp, copy bookkeeping.
// ---------------------------------------------------------------------------
module spr_back import spr_pkg::*; #(
  parameter int MAX_PARTICLES    = DEF_MAX_PARTICLES,
  parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS,
  localparam int SW = WEIGHT_FRAC_BITS + 2,
  localparam int IW = $clog2(MAX_PARTICLES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [W_COUNT-1:0]  particle_count,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  spr_pose_t           pop_pose,
  input  logic [SW-1:0]       pop_sum,
  input  logic [W_OFFSET-1:0] pop_offset,
  input  spr_flags_t          pop_flags,
  input  logic [IW-1:0]       pop_idx,
  spr_out_if.source           out_chan
);

  localparam int F    = WEIGHT_FRAC_BITS;
  localparam int CMAX = (1 << W_COUNT) - 1;
  localparam int NMAX = (MAX_PARTICLES < CMAX) ? MAX_PARTICLES : CMAX;
  localparam int NW   = $clog2(NMAX + 1);
  localparam int PW   = SW + NW;
  localparam int QW   = PW - F;
  localparam int KW   = QW + 1;

  logic [NW-1:0]       n_eff;

  // stage 1: product of sum and count
  logic                s1_v_r;
  logic [PW-1:0]       s1_prod_r;
  logic [W_OFFSET-1:0] s1_off_r;
  logic [NW-1:0]       s1_n_r;
  spr_flags_t          s1_flags_r;
  spr_pose_t           s1_pose_r;
  logic [IW-1:0]       s1_idx_r;

  // stage 2: output register
  logic                out_v_r;
  spr_pose_t           out_pose_r;
  logic [W_COUNT-1:0]  copies_r;
  logic [W_INDEX-1:0]  idx_r;
  logic                done_r;
  logic [W_COUNT-1:0]  emitted_r, emitted_nxt;

  logic                s2_free, s2_load, s1_free, s1_load;
  logic [QW-1:0]       q;
  logic [F-1:0]        r;
  logic [F+15:0]       r_sh, u_sh;
  logic [KW-1:0]       cnt;
  logic [W_COUNT-1:0]  total, base, copies_nxt;

  always_comb begin
    if (particle_count == '0) begin
      n_eff = NW'(1);
    end else if (32'(particle_count) > NMAX) begin
      n_eff = NW'(NMAX);
    end else begin
      n_eff = NW'(particle_count);
    end
  end

  assign s2_free   = !out_v_r || out_chan.ready;
  assign s2_load   = s1_v_r && s2_free;
  assign s1_free   = !s1_v_r || s2_load;
  assign s1_load   = pop_valid && s1_free;
  assign pop_ready = s1_free;

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_prod_r  <= PW'(pop_sum) * PW'(n_eff);
      s1_off_r   <= pop_offset;
      s1_n_r     <= n_eff;
      s1_flags_r <= pop_flags;
      s1_pose_r  <= pop_pose;
      s1_idx_r   <= pop_idx;
    end
  end

  // P = q*2^F + r; the count is q, plus one when r*2^16 > u*2^F
  always_comb begin
    q    = s1_prod_r[PW-1:F];
    r    = s1_prod_r[F-1:0];
    r_sh = {r, {W_OFFSET{1'b0}}};
    u_sh = {s1_off_r, {F{1'b0}}};
    cnt  = KW'(q) + KW'(r_sh > u_sh);
    if (s1_flags_r.last || (cnt > KW'(s1_n_r))) begin
      total = W_COUNT'(s1_n_r);
    end else begin
      total = W_COUNT'(cnt);
    end
    base        = s1_flags_r.first ? '0 : emitted_r;
    copies_nxt  = (total > base) ? total - base : '0;
    emitted_nxt = base + copies_nxt;
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_pose_r <= s1_pose_r;
      copies_r   <= copies_nxt;
      idx_r      <= W_INDEX'(s1_idx_r);
      done_r     <= s1_flags_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      emitted_r <= '0;
    end else begin
      if (s1_free) begin
        s1_v_r <= pop_valid;
      end
      if (s2_free) begin
        out_v_r <= s1_v_r;
      end
      if (s2_load) begin
        emitted_r <= emitted_nxt;
      end
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.out_x        = out_pose_r.x;
  assign out_chan.out_y        = out_pose_r.y;
  assign out_chan.out_heading  = out_pose_r.heading;
  assign out_chan.copies       = copies_r;
  assign out_chan.source_index = idx_r;
  assign out_chan.set_done     = done_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_free |=> s1_v_r)
    else $error("stalled stage 1 request dropped");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_chan.ready && !s2_load |=> !out_v_r)
    else $error("result repeated after hand-off");

endmodule

/* hw/rtl/systematic_particle_resampler.sv */
// ---------------------------------------------------------------------------
// systematic_particle_resampler
// Systematic resampling of a particle stream into per-particle copy counts.
// ---------------------------------------------------------------------------
// One particle is taken per clock while the queue has room, and one result
// per particle is returned, in order, through the queue, the stage 1 product
// register and the output register. The rate is set by the running weight sum
// register in the front half and the copies-given register in the back half,
// each updated once per particle. A four-entry queue parts the two halves,
// and the output register lets a new particle enter while a result waits.
// particle_count may be written at any time the block is idle; a value of 0
// acts as 1 and one above MAX_PARTICLES acts as MAX_PARTICLES. No clearing
// pass is needed after reset.
module systematic_particle_resampler import spr_pkg::*; #(
  parameter int MAX_PARTICLES    = DEF_MAX_PARTICLES,
  parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  spr_in_if.sink     in_chan,
  spr_out_if.source  out_chan,
  spr_cfg_if.sink    cfg_chan
);

  localparam int SW = WEIGHT_FRAC_BITS + 2;
  localparam int IW = $clog2(MAX_PARTICLES);
  localparam int QW = $bits(spr_pose_t) + SW + W_OFFSET + $bits(spr_flags_t) + IW;

  logic [W_COUNT-1:0]  count_r;

  logic                f_valid, f_ready;
  spr_pose_t           f_pose;
  logic [SW-1:0]       f_sum;
  logic [W_OFFSET-1:0] f_offset;
  spr_flags_t          f_flags;
  logic [IW-1:0]       f_idx;

  logic                b_valid, b_ready;
  spr_pose_t           b_pose;
  logic [SW-1:0]       b_sum;
  logic [W_OFFSET-1:0] b_offset;
  spr_flags_t          b_flags;
  logic [IW-1:0]       b_idx;
  logic [QW-1:0]       q_in, q_out;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_chan.valid) begin
      count_r <= cfg_chan.data;
    end
  end

  spr_front #(
    .MAX_PARTICLES    (MAX_PARTICLES),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .push_valid  (f_valid),
    .push_ready  (f_ready),
    .push_pose   (f_pose),
    .push_sum    (f_sum),
    .push_offset (f_offset),
    .push_flags  (f_flags),
    .push_idx    (f_idx)
  );

  assign q_in = {f_pose, f_sum, f_offset, f_flags, f_idx};

  spr_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (q_in),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (q_out)
  );

  assign {b_pose, b_sum, b_offset, b_flags, b_idx} = q_out;

  spr_back #(
    .MAX_PARTICLES    (MAX_PARTICLES),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .particle_count (count_r),
    .pop_valid      (b_valid),
    .pop_ready      (b_ready),
    .pop_pose       (b_pose),
    .pop_sum        (b_sum),
    .pop_offset     (b_offset),
    .pop_flags      (b_flags),
    .pop_idx        (b_idx),
    .out_chan       (out_chan)
  );

endmodule

/* dv/tb_systematic_particle_resampler.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_systematic_particle_resampler
// Self-checking bench for the systematic particle resampler.
// ---------------------------------------------------------------------------
// Particles go in with random gaps and results come out with random back
// pressure. A local copy of the resampling arithmetic predicts the pose, copy
// count, index and set flag of every result, and the results are compared in
// order. The directed tests cover the corner cases: count limits, sum
// saturation, offset rounding, a count lowered mid-set and index wrap. The
// random part consists mostly of sets with weights that add up to 1.0.
module tb_systematic_particle_resampler;
  import spr_pkg::*;

  localparam int MAXP         = DEF_MAX_PARTICLES;
  localparam int WFB          = DEF_WEIGHT_FRAC_BITS;
  localparam int ONE          = 1 << WFB;
  localparam int RANDOM_ITEMS = 890;
  localparam int LONG_SET     = 1030;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 8;
  localparam int SUM_W        = WFB + 3;
  localparam int PROD_W       = WFB + W_COUNT + 2;

  localparam logic [WFB+1:0] WSUM_MAX = '1;

  typedef struct {
    spr_pose_t           pose;
    logic [W_WEIGHT-1:0] weight;
    logic [W_OFFSET-1:0] offset;
    logic                last;
  } particle_t;

  typedef struct {
    spr_pose_t          pose;
    logic [W_COUNT-1:0] copies;
    logic [W_INDEX-1:0] src_index;
    logic               set_done;
  } resampled_t;

  logic clk;
  logic rst_n;

  spr_in_if  in_if ();
  spr_out_if out_if ();
  spr_cfg_if cfg_if ();

  systematic_particle_resampler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // local copy of the resampler state
  logic [W_COUNT-1:0]  count_reg    = COUNT_RESET;
  logic [WFB+1:0]      acc_weight   = '0;
  logic [W_COUNT-1:0]  copies_given = '0;
  logic [W_OFFSET-1:0] set_offset   = '0;
  logic [W_INDEX-1:0]  next_index   = '0;
  logic                opening_set  = 1'b1;

  resampled_t resampled_q[$];
  int         errors         = 0;
  int         particles_sent = 0;
  int         cycles         = 0;
  bit         gaps_on        = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic resampled_t resample_step(input particle_t p);
    resampled_t                   r;
    logic [W_COUNT-1:0]           n;
    logic [WFB+2:0]               sum_wide;
    logic [WFB+W_COUNT+1:0]       prod;
    logic [WFB+W_COUNT+1:0]       passed;
    logic [WFB+15:0]              frac_scaled;
    logic [WFB+15:0]              off_scaled;
    n = count_reg;
    if (n == '0) n = W_COUNT'(1);
    else if (n > W_COUNT'(MAXP)) n = W_COUNT'(MAXP);
    if (opening_set) begin
      set_offset   = p.offset;
      acc_weight   = '0;
      copies_given = '0;
      next_index   = '0;
      opening_set  = 1'b0;
    end
    sum_wide   = SUM_W'(acc_weight) + SUM_W'(p.weight);
    acc_weight = (sum_wide > SUM_W'(WSUM_MAX)) ? WSUM_MAX : sum_wide[WFB+1:0];
    if (p.last) begin
      passed = PROD_W'(n);
    end else begin
      // threshold m counts when (u + m) / N < S, done exactly on S*N
      prod        = PROD_W'(acc_weight) * PROD_W'(n);
      passed      = prod >> WFB;
      frac_scaled = {prod[WFB-1:0], 16'b0};
      off_scaled  = {set_offset, {WFB{1'b0}}};
      if (frac_scaled > off_scaled) passed = passed + PROD_W'(1);
      if (passed > PROD_W'(n)) passed = PROD_W'(n);
    end
    r.copies     = (passed > PROD_W'(copies_given))
                   ? W_COUNT'(passed - PROD_W'(copies_given)) : '0;
    copies_given = copies_given + r.copies;
    r.src_index  = next_index;
    next_index   = (next_index >= MAXP - 1) ? '0 : next_index + 1'b1;
    if (p.last) opening_set = 1'b1;
    r.pose     = p.pose;
    r.set_done = p.last;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic particle_t make_particle(input int w, input int off, input bit last);
    particle_t p;
    p.pose.x       = $urandom;
    p.pose.y       = $urandom;
    p.pose.heading = W_HEADING'($urandom);
    p.weight       = W_WEIGHT'(w);
    p.offset       = W_OFFSET'(off);
    p.last         = last;
    return p;
  endfunction

  task automatic send_particle(input particle_t p);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid         <= 1'b1;
    in_if.pos_x         <= p.pose.x;
    in_if.pos_y         <= p.pose.y;
    in_if.heading       <= p.pose.heading;
    in_if.weight        <= p.weight;
    in_if.random_offset <= p.offset;
    in_if.last          <= p.last;
    do @(posedge clk); while (!in_if.ready);
    resampled_q.push_back(resample_step(p));
    particles_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (resampled_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_particle_count(input logic [W_COUNT-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    count_reg = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // weights of a well-formed set add up to exactly 1.0
  task automatic send_normalised_set(input int len);
    int left;
    int w;
    left = ONE;
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) begin
        w = left;
      end else begin
        w = $urandom_range(0, 2 * left / (len - i));
        if (w > left) w = left;
      end
      left -= w;
      send_particle(make_particle(w, $urandom, i == len - 1));
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_particle(make_particle($urandom_range(0, ONE), $urandom,
                                  $urandom_range(0, 3) == 0));
  endtask

  // reset value of the count, pose extremes, zero weights and sum saturation
  task automatic test_reset_count();
    particle_t p;
    p = make_particle(ONE, 'hFFFF, 1'b1);
    p.pose.x       = 32'h7FFF_FFFF;
    p.pose.y       = 32'h8000_0000;
    p.pose.heading = 16'h7FFF;
    send_particle(p);
    p = make_particle(0, 0, 1'b0);
    p.pose.x       = 32'h8000_0000;
    p.pose.y       = 32'h7FFF_FFFF;
    p.pose.heading = 16'h8000;
    send_particle(p);
    p = make_particle(ONE, 'hFFFF, 1'b0);
    p.pose.x       = '0;
    p.pose.y       = '1;
    p.pose.heading = '0;
    send_particle(p);
    send_particle(make_particle(0, 0, 1'b1));
    repeat (4) send_particle(make_particle(ONE, $urandom, 1'b0));
    send_particle(make_particle(ONE, $urandom, 1'b1));
  endtask

  // count of zero acts as one, counts above the maximum are clipped
  task automatic test_count_limits();
    write_particle_count('0);
    send_particle(make_particle(ONE / 2, 'h8000, 1'b0));
    send_particle(make_particle(ONE / 2, 0, 1'b1));
    write_particle_count(W_COUNT'(MAXP + 1));
    send_particle(make_particle(ONE / 2, 0, 1'b1));
    write_particle_count('1);
    send_particle(make_particle(ONE / 2, 'h1234, 1'b0));
    send_particle(make_particle(ONE / 2, 0, 1'b1));
    write_particle_count(W_COUNT'(1));
    send_particle(make_particle(ONE / 4, 0, 1'b0));
    send_particle(make_particle(3 * ONE / 4, 0, 1'b1));
    // a quarter weight with N=2 lands between the two offset extremes
    write_particle_count(W_COUNT'(2));
    send_particle(make_particle(ONE / 4, 0, 1'b0));
    send_particle(make_particle(3 * ONE / 4, 0, 1'b1));
    send_particle(make_particle(ONE / 4, 'hFFFF, 1'b0));
    send_particle(make_particle(3 * ONE / 4, 0, 1'b1));
  endtask

  // copies already given exceed the new count, so nothing more is handed out
  task automatic test_count_lowered();
    write_particle_count(W_COUNT'(8));
    send_particle(make_particle(ONE / 2, 'h4000, 1'b0));
    send_particle(make_particle(ONE / 4, 0, 1'b0));
    send_particle(make_particle(ONE / 4, 0, 1'b0));
    write_particle_count(W_COUNT'(2));
    send_particle(make_particle(0, 0, 1'b0));
    send_particle(make_particle(0, 0, 1'b1));
  endtask

  // set longer than the particle store: index wraps, copies run out
  task automatic test_long_set();
    write_particle_count(W_COUNT'(4));
    for (int i = 0; i < LONG_SET; i++)
      send_particle(make_particle($urandom_range(0, 1 << 15), $urandom, i == LONG_SET - 1));
  endtask

  task automatic test_random_sets();
    int r;
    int target;
    target = particles_sent + RANDOM_ITEMS;
    while (particles_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 70)      write_particle_count(W_COUNT'($urandom_range(1, 16)));
      else if (r < 85) write_particle_count(W_COUNT'($urandom_range(17, 64)));
      else if (r < 89) write_particle_count(W_COUNT'(MAXP));
      else if (r < 93) write_particle_count(W_COUNT'($urandom_range(MAXP + 1, 2047)));
      else if (r < 96) write_particle_count('0);
      else             write_particle_count(W_COUNT'($urandom_range(65, MAXP - 1)));
      gaps_on = ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 99) < 80)
          send_normalised_set(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                          : $urandom_range(1, 12));
        else
          send_noise();
      end
      if ($urandom_range(0, 3) == 0) drain_results();
    end
    gaps_on = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    resampled_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (resampled_q.size() == 0) begin
        $error("result with no request outstanding: copies %0d index %0d",
               out_if.copies, out_if.source_index);
        errors++;
      end else begin
        want = resampled_q.pop_front();
        check_field("out_x", want.pose.x, out_if.out_x);
        check_field("out_y", want.pose.y, out_if.out_y);
        check_field("out_heading", 32'(want.pose.heading), 32'(out_if.out_heading));
        check_field("copies", 32'(want.copies), 32'(out_if.copies));
        check_field("source_index", 32'(want.src_index), 32'(out_if.source_index));
        check_field("set_done", 32'(want.set_done), 32'(out_if.set_done));
      end
    end
  end

  initial begin : result_ready
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = pick_gap();
      repeat (stall) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("systematic_particle_resampler: mismatch");
    $finish;
  end

  initial begin : run
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.pos_x         = '0;
    in_if.pos_y         = '0;
    in_if.heading       = '0;
    in_if.weight        = '0;
    in_if.random_offset = '0;
    in_if.last          = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.data         = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_count();
    test_count_limits();
    test_count_lowered();
    test_long_set();
    test_random_sets();
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("systematic_particle_resampler: match");
    else $display("systematic_particle_resampler: mismatch");
    $finish;
  end

endmodule
